[sv/lmtf_pkg.sv]
// shared types and constants of the move-to-front cache
// no dependencies; imported by lmtf_cell, lru_move_to_front_cache, the monitor and the bench
package lmtf_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FILL_W  = 4;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // what one cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_FRONT = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port_in;
    logic [ADDR_W-1:0] addr_in;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port_out;
    logic [ADDR_W-1:0] addr_out;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

endpackage

[sv/lmtf_cell.sv]
// one list slot: holds an entry, compares its key, loads from a neighbor
// depends on lmtf_pkg
module lmtf_cell import lmtf_pkg::*; (
  input  logic             clk_i,
  input  cell_op_e         op_i,
  input  entry_t           front_i,
  input  entry_t           left_i,
  input  entry_t           right_i,
  input  logic [KEY_W-1:0] cmp_key_i,
  output entry_t           entry_o,
  output logic             key_eq_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    case (op_i)
      CELL_FRONT: entry_d = front_i;
      CELL_LEFT:  entry_d = left_i;
      CELL_RIGHT: entry_d = right_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o  = entry_q;
  assign key_eq_o = (entry_q.key == cmp_key_i);

endmodule

[sv/lru_move_to_front_cache.sv]
// move-to-front cache: a row of ENTRIES cells, most recent entry in cell 0
// all cells compare and shift in the same edge; the result is registered
// throughput: one item per cycle unless a stuck result stalls the input
// reset: fill count and output valid clear at once; cell contents are not reset
// depends on lmtf_pkg and lmtf_cell
module lru_move_to_front_cache import lmtf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  // list state
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  // per-cell signals
  entry_t         cell_entry [ENTRIES];
  logic           cell_key_eq [ENTRIES];
  cell_op_e       cell_op    [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] ahead;   // a match at this cell or nearer the front
  logic [ENTRIES-1:0] first;   // the match nearest the front

  entry_t hit_entry;
  entry_t new_entry;
  entry_t front_entry;
  logic   any_match;
  logic   accept;

  // output register
  logic      out_valid_q;
  logic      out_valid_d;
  out_item_t out_q;
  out_item_t out_d;

  // a new item enters unless a finished result is stuck in the output register
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // the row of cells, each fed by both neighbors
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t left_in;
    entry_t right_in;

    if (i == 0) begin : g_head
      assign left_in = front_entry;
    end else begin : g_body
      assign left_in = cell_entry[i-1];
    end

    // the tail has no right neighbor and keeps its own entry
    if (i == ENTRIES - 1) begin : g_tail
      assign right_in = cell_entry[i];
    end else begin : g_mid
      assign right_in = cell_entry[i+1];
    end

    lmtf_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op[i]),
      .front_i   (front_entry),
      .left_i    (left_in),
      .right_i   (right_in),
      .cmp_key_i (in_i.key),
      .entry_o   (cell_entry[i]),
      .key_eq_o  (cell_key_eq[i])
    );

    // slots below the count hold live entries
    assign cell_valid[i] = (count_q > CNT_W'(i));
    assign match[i]      = cell_valid[i] & cell_key_eq[i];
  end

  // priority: the match nearest the front wins
  always_comb begin
    ahead[0] = match[0];
    for (int i = 1; i < ENTRIES; i++) begin
      ahead[i] = ahead[i-1] | match[i];
    end
    first[0] = match[0];
    for (int i = 1; i < ENTRIES; i++) begin
      first[i] = match[i] & ~ahead[i-1];
    end
  end

  assign any_match = ahead[ENTRIES-1];

  // one-hot select of the found entry
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first[i]) begin
        hit_entry = hit_entry | cell_entry[i];
      end
    end
  end

  assign new_entry.key  = in_i.key;
  assign new_entry.port = in_i.port_in;
  assign new_entry.addr = in_i.addr_in;

  // cell 0 takes the new entry on add, the found entry on lookup
  assign front_entry = (in_i.opcode == OP_ADD) ? new_entry : hit_entry;

  // per-cell moves
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept) begin
        unique case (in_i.opcode)
          OP_LOOKUP: begin
            // cells up to the found one slide back, found entry goes to front
            if (any_match) begin
              if (i == 0) begin
                cell_op[i] = CELL_FRONT;
              end else if (!ahead[i-1]) begin
                cell_op[i] = CELL_LEFT;
              end
            end
          end
          OP_ADD: begin
            // whole row slides back, the tail entry falls off
            cell_op[i] = (i == 0) ? CELL_FRONT : CELL_LEFT;
          end
          OP_REMOVE: begin
            // the found cell and those behind it pull forward
            if (ahead[i]) begin
              cell_op[i] = CELL_RIGHT;
            end
          end
          default: begin
            cell_op[i] = CELL_HOLD;
          end
        endcase
      end
    end
  end

  // fill count and result
  always_comb begin
    count_d          = count_q;
    out_d.hit        = 1'b0;
    out_d.port_out   = '0;
    out_d.addr_out   = '0;
    unique case (in_i.opcode)
      OP_LOOKUP: begin
        if (any_match) begin
          out_d.hit      = 1'b1;
          out_d.port_out = hit_entry.port;
          out_d.addr_out = hit_entry.addr;
        end
      end
      OP_ADD: begin
        out_d.hit = 1'b1;
        if (count_q < CNT_W'(ENTRIES)) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (any_match) begin
          out_d.hit = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    out_d.fill_count = FILL_W'(count_d);
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[verif/lmtf_cache_monitor.sv]
`timescale 1ns / 1ps
// channel monitor for the move-to-front cache: mirrors the entry list,
// predicts one reply per accepted request and compares replies in order
// depends on lmtf_pkg
module lmtf_cache_monitor import lmtf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        reply_count_o,
  output int        hit_count_o
);

  entry_t    mirror_cells [ENTRIES];
  int        mirror_fill;
  out_item_t pending_replies [$];
  int        fail_count;
  int        reply_count;
  int        hit_count;

  function automatic int find_entry(input logic [KEY_W-1:0] key);
    for (int i = 0; i < mirror_fill; i++) begin
      if (mirror_cells[i].key == key) return i;
    end
    return -1;
  endfunction

  // update the mirror list for one request and build its reply
  task automatic apply_request(input in_item_t req, output out_item_t reply);
    int     slot;
    entry_t moved;
    reply = '0;
    case (req.opcode)
      OP_LOOKUP: begin
        slot = find_entry(req.key);
        if (slot >= 0) begin
          moved = mirror_cells[slot];
          for (int i = slot; i > 0; i--) mirror_cells[i] = mirror_cells[i-1];
          mirror_cells[0] = moved;
          reply.hit      = 1'b1;
          reply.port_out = moved.port;
          reply.addr_out = moved.addr;
        end
      end
      OP_ADD: begin
        // full list: the least recent entry falls off the end
        if (mirror_fill >= ENTRIES) mirror_fill = ENTRIES - 1;
        for (int i = mirror_fill; i > 0; i--) mirror_cells[i] = mirror_cells[i-1];
        mirror_cells[0].key  = req.key;
        mirror_cells[0].port = req.port_in;
        mirror_cells[0].addr = req.addr_in;
        mirror_fill++;
        reply.hit = 1'b1;
      end
      OP_REMOVE: begin
        slot = find_entry(req.key);
        if (slot >= 0) begin
          for (int i = slot; i + 1 < mirror_fill; i++) mirror_cells[i] = mirror_cells[i+1];
          mirror_fill--;
          reply.hit = 1'b1;
        end
      end
      default: ;
    endcase
    reply.fill_count = FILL_W'(mirror_fill);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t predicted;
    if (!rst_ni) begin
      mirror_fill = 0;
      pending_replies.delete();
      fail_count  = 0;
      reply_count = 0;
      hit_count   = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      reply_count_o <= 0;
      hit_count_o   <= 0;
    end else begin
      // replies are registered, so the oldest prediction is retired first
      if (out_valid_i && !out_stall_i) begin
        reply_count++;
        if (out_item_i.hit) hit_count++;
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected reply: hit %b port %h addr %h fill %0d", $realtime,
                     out_item_i.hit, out_item_i.port_out, out_item_i.addr_out,
                     out_item_i.fill_count);
        end else begin
          want = pending_replies.pop_front();
          if (out_item_i.hit !== want.hit || out_item_i.port_out !== want.port_out ||
              out_item_i.addr_out !== want.addr_out ||
              out_item_i.fill_count !== want.fill_count) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] reply mismatch: exp hit %b port %h addr %h fill %0d",
                       $realtime, want.hit, want.port_out, want.addr_out, want.fill_count);
              $display("       got hit %b port %h addr %h fill %0d",
                       out_item_i.hit, out_item_i.port_out, out_item_i.addr_out,
                       out_item_i.fill_count);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(in_item_i, predicted);
        pending_replies.push_back(predicted);
      end
      fail_count_o  <= fail_count;
      pending_o     <= pending_replies.size();
      reply_count_o <= reply_count;
      hit_count_o   <= hit_count;
    end
  end

endmodule

[verif/lru_move_to_front_cache_tb.sv]
`timescale 1ns / 1ps
// top of the move-to-front cache bench: clock, reset, request stimulus,
// random reply stalls, watchdog and verdict; depends on lmtf_pkg,
// lmtf_cache_monitor and lru_move_to_front_cache
module lru_move_to_front_cache_tb import lmtf_pkg::*;;

  // opcode that the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT       = 38;
  localparam int RANDOM_ITEMS   = 630;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_SIZE      = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;

  int fail_count;
  int pending;
  int reply_count;
  int hit_count;
  int items_sent;
  int quiet_cycles;
  logic stall_free;    // set during the stretch with no idling on either side

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lru_move_to_front_cache dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  lmtf_cache_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_item_i     (in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_i    (out_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .reply_count_o (reply_count),
    .hit_count_o   (hit_count)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // reply side: random back-pressure, changed only at the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !stall_free && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: any cycle without a handshake on either channel counts
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one request item; entered and left at a falling edge, valid stays
  // high on exit so a back-to-back item needs no lowering in the same step
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [PORT_W-1:0] port, input logic [ADDR_W-1:0] addr);
    in_item_t req;
    req.opcode  = op;
    req.key     = key;
    req.port_in = port;
    req.addr_in = addr;
    // random gaps before the item
    while (!stall_free && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    // item is taken at the first rising edge without stall
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int pick;
    int op_roll;
    int add_weight;
    int remove_weight;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_i         = '0;
    items_sent   = 0;
    quiet_cycles = 0;
    stall_free   = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // misses and the no-op on an empty list
    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_REMOVE, '1, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1);
    // extreme keys and payloads
    send_request(OP_ADD, '0, '0, '0);
    send_request(OP_ADD, '1, '1, '1);
    // duplicate key: the newer copy sits nearer the front
    send_request(OP_ADD, '1, 16'h1234, 32'h0a00_0001);
    send_request(OP_LOOKUP, '1, '0, '0);
    // lookup that moves the tail entry to the front
    send_request(OP_LOOKUP, '0, '1, '1);
    // remove takes the nearest duplicate, the older copy stays reachable
    send_request(OP_REMOVE, '1, '0, '0);
    send_request(OP_LOOKUP, '1, '0, '0);
    // fill the list, then overflow it so the least recent entry drops
    for (int i = 0; i < ENTRIES - 1; i++)
      send_request(OP_ADD, 64'h100 + i, PORT_W'(i), ADDR_W'($urandom));
    send_request(OP_LOOKUP, '1, '0, '0);
    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_LOOKUP, 64'h100, '0, '0);
    send_request(OP_REMOVE, 64'h103, '0, '0);
    send_request(OP_UNUSED, 64'h104, '0, '0);
    send_request(OP_REMOVE, 64'hdead_beef_0000_0001, '0, '0);

    // ---- random part ----
    // keys mostly come from a small pool so lookups and removes find them
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a long stretch with no idling on either channel
      stall_free <= (n >= 280 && n < 400);
      // alternate between filling and draining phases to reach full and empty
      if (((n / 50) % 2) == 0) begin
        add_weight    = 45;
        remove_weight = 15;
      end else begin
        add_weight    = 15;
        remove_weight = 45;
      end
      if ((n % 40) == 39) key_pool[$urandom_range(POOL_SIZE - 1)] = rand_key();
      op_roll = $urandom_range(99);
      if (op_roll < 5)
        op = OP_UNUSED;
      else if (op_roll < 5 + add_weight)
        op = OP_ADD;
      else if (op_roll < 5 + add_weight + remove_weight)
        op = OP_REMOVE;
      else
        op = OP_LOOKUP;
      pick = $urandom_range(99);
      key  = (pick < 88) ? key_pool[$urandom_range(POOL_SIZE - 1)] : rand_key();
      send_request(op, key, PORT_W'($urandom), ADDR_W'($urandom));
    end
    stall_free <= 1'b0;
    in_valid_i <= 1'b0;

    // drain: every predicted reply must arrive, then a short settle
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests (lookup, add, remove, unused opcode) with random gaps",
             items_sent);
    $display("%0d replies checked, %0d of them hits, %0d failures", reply_count, hit_count,
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
